[hdl/led64_pkg.sv]
// shared types, constants and tables for the led64 block encryption core
`timescale 1ns / 1ps

package led64_pkg;

  localparam int LED_BLOCK_W    = 64;
  localparam int LED_KEY_W      = 64;
  localparam int LED_RC_DEPTH   = 48;
  localparam int LED_RND_W      = 6;
  localparam int LED_NUM_ROUNDS = 32;

  // key-size nibbles mixed with the row number, column 0 of every row
  localparam logic [LED_BLOCK_W-1:0] LED_RC_BASE = 64'h4000500020003000;

  // MDS rows, element k of a row in bits 15-4k..12-4k
  localparam logic [3:0][15:0] LED_MDS = {16'h22fb, 16'hbea9, 16'h8656, 16'h4122};

  // round constant table
  localparam logic [LED_RC_DEPTH-1:0][5:0] LED_RC = {
    6'h04, 6'h22, 6'h11, 6'h08, 6'h24, 6'h12, 6'h29, 6'h34,
    6'h1A, 6'h2D, 6'h36, 6'h1B, 6'h0D, 6'h06, 6'h23, 6'h31,
    6'h38, 6'h1C, 6'h2E, 6'h17, 6'h0B, 6'h05, 6'h02, 6'h21,
    6'h30, 6'h18, 6'h2C, 6'h16, 6'h2B, 6'h35, 6'h3A, 6'h1D,
    6'h0E, 6'h27, 6'h33, 6'h39, 6'h3C, 6'h1E, 6'h2F, 6'h37,
    6'h3B, 6'h3D, 6'h3E, 6'h1F, 6'h0F, 6'h07, 6'h03, 6'h01
  };

  // commands from the controller to the datapath
  typedef struct packed {
    logic                 load;      // state <= plaintext ^ key
    logic                 round;     // run one round on the state
    logic                 add_key;   // add the key after this round
    logic [LED_RND_W-1:0] rnd;       // round number
    logic                 out_load;  // copy the state into the output register
  } led64_cmd_t;

endpackage

[hdl/led64_if.sv]
// plaintext and ciphertext stream interfaces
`timescale 1ns / 1ps

interface led64_pt_if;
  import led64_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [LED_BLOCK_W-1:0] plaintext;
  modport source (output valid, output plaintext, input ready);
  modport sink (input valid, input plaintext, output ready);
endinterface

interface led64_ct_if;
  import led64_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [LED_BLOCK_W-1:0] ciphertext;
  modport source (output valid, output ciphertext, input ready);
  modport sink (input valid, input ciphertext, output ready);
endinterface

[hdl/led64_dp.sv]
// led64 datapath: key register, round state, one round per cycle, output register
`timescale 1ns / 1ps

module led64_dp (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             key_wr_en,
  input  logic [led64_pkg::LED_KEY_W-1:0]  key_wr_data,
  input  logic [led64_pkg::LED_BLOCK_W-1:0] plaintext,
  input  led64_pkg::led64_cmd_t            cmd,
  output logic [led64_pkg::LED_BLOCK_W-1:0] ciphertext
);
  import led64_pkg::*;

  logic [LED_KEY_W-1:0]   key;
  logic [LED_BLOCK_W-1:0] state;
  logic [LED_BLOCK_W-1:0] state_next;
  logic [LED_BLOCK_W-1:0] round_out;

  function automatic logic [3:0] sbox(input logic [3:0] v);
    logic [3:0] r;
    case (v)
      4'h0: r = 4'hC;  4'h1: r = 4'h5;  4'h2: r = 4'h6;  4'h3: r = 4'hB;
      4'h4: r = 4'h9;  4'h5: r = 4'h0;  4'h6: r = 4'hA;  4'h7: r = 4'hD;
      4'h8: r = 4'h3;  4'h9: r = 4'hE;  4'hA: r = 4'hF;  4'hB: r = 4'h8;
      4'hC: r = 4'h4;  4'hD: r = 4'h7;  4'hE: r = 4'h1;  4'hF: r = 4'h2;
      default: r = 4'h0;
    endcase
    return r;
  endfunction

  // multiply in GF(16), polynomial x^4+x+1
  function automatic logic [3:0] gf_mul(input logic [3:0] a, input logic [3:0] b);
    logic [3:0] x;
    logic [3:0] acc;
    x   = a;
    acc = 4'h0;
    for (int i = 0; i < 4; i++) begin
      if (b[i]) acc = acc ^ x;
      x = {x[2:0], 1'b0} ^ (x[3] ? 4'h3 : 4'h0);
    end
    return acc;
  endfunction

  // one full round: constants, s-box, row rotation, column mixing
  always_comb begin
    logic [5:0]             rc;
    logic [LED_BLOCK_W-1:0] s;
    logic [3:0]             nib [16];
    logic [3:0]             sh [16];
    logic [3:0]             acc;
    rc = LED_RC[cmd.rnd];
    s  = state ^ LED_RC_BASE
       ^ (LED_BLOCK_W'(rc[5:3]) << 56) ^ (LED_BLOCK_W'(rc[2:0]) << 40)
       ^ (LED_BLOCK_W'(rc[5:3]) << 24) ^ (LED_BLOCK_W'(rc[2:0]) << 8);
    for (int k = 0; k < 16; k++) begin
      nib[k] = sbox(s[LED_BLOCK_W-1-4*k -: 4]);
    end
    for (int row = 0; row < 4; row++) begin
      for (int col = 0; col < 4; col++) begin
        sh[row*4+col] = nib[row*4 + ((col + row) & 3)];
      end
    end
    round_out = '0;
    for (int row = 0; row < 4; row++) begin
      for (int col = 0; col < 4; col++) begin
        acc = 4'h0;
        for (int k = 0; k < 4; k++) begin
          acc = acc ^ gf_mul(LED_MDS[row][15-4*k -: 4], sh[k*4+col]);
        end
        round_out[LED_BLOCK_W-1-4*(row*4+col) -: 4] = acc;
      end
    end
  end

  // next state select
  always_comb begin
    state_next = state;
    if (cmd.load) begin
      state_next = plaintext ^ key;
    end else if (cmd.round) begin
      state_next = cmd.add_key ? (round_out ^ key) : round_out;
    end
  end

  // key register
  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
    end else if (key_wr_en) begin
      key <= key_wr_data;
    end
  end

  // state and output registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else begin
      state <= state_next;
    end
    if (cmd.out_load) begin
      ciphertext <= state;
    end
  end

endmodule

[hdl/led64_ctrl.sv]
// led64 controller: round sequencer and output handshake
`timescale 1ns / 1ps

module led64_ctrl #(
  parameter int NUM_ROUNDS = led64_pkg::LED_NUM_ROUNDS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  output led64_pkg::led64_cmd_t cmd
);
  import led64_pkg::*;

  localparam int TOTAL = (NUM_ROUNDS > LED_RC_DEPTH) ? LED_RC_DEPTH : NUM_ROUNDS;
  localparam logic [LED_RND_W-1:0] LAST = LED_RND_W'(TOTAL - 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t               state;
  state_t               state_next;
  logic [LED_RND_W-1:0] rnd;
  logic [LED_RND_W-1:0] rnd_next;
  logic                 out_free;

  assign out_free = !out_valid || out_ready;

  // sequencing and command decode
  always_comb begin
    state_next   = state;
    rnd_next     = rnd;
    in_ready     = 1'b0;
    cmd          = '0;
    cmd.rnd      = rnd;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          rnd_next   = '0;
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd.round   = 1'b1;
        cmd.add_key = (rnd[1:0] == 2'b11) || (rnd == LAST);
        if (rnd == LAST) begin
          state_next = ST_DONE;
        end else begin
          rnd_next = rnd + LED_RND_W'(1);
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rnd       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      rnd   <= rnd_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[hdl/led64_block_encrypt_top.sv]
// led64 block encryption top level: key port, plaintext in, ciphertext out
// the plaintext transaction loads the state, the rounds then run one per cycle, and
//   the result is copied into the output register
// a new plaintext is taken only after that copy, which waits while the previous
//   ciphertext still waits for its transaction
// reset: controller idle, output invalid, key register and round state cleared to zero
`timescale 1ns / 1ps

module led64_block_encrypt_top #(
  parameter int NUM_ROUNDS = led64_pkg::LED_NUM_ROUNDS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             key_wr_en,
  input  logic [led64_pkg::LED_KEY_W-1:0]  key_wr_data,
  led64_pt_if.sink                         pt_in,
  led64_ct_if.source                       ct_out
);
  import led64_pkg::*;

  led64_cmd_t cmd;

  // round sequencer
  led64_ctrl #(
    .NUM_ROUNDS(NUM_ROUNDS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pt_in.valid),
    .in_ready  (pt_in.ready),
    .out_valid (ct_out.valid),
    .out_ready (ct_out.ready),
    .cmd       (cmd)
  );

  // round datapath
  led64_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .key_wr_en   (key_wr_en),
    .key_wr_data (key_wr_data),
    .plaintext   (pt_in.plaintext),
    .cmd         (cmd),
    .ciphertext  (ct_out.ciphertext)
  );

  // a loaded block starts its rounds at once and blocks new transactions
  a_load_then_round: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> cmd.round && (cmd.rnd == '0) && !pt_in.ready)
    else $error("round did not start after load");

  // the first round always follows a load
  a_first_round: assert property (@(posedge clk) disable iff (rst)
    cmd.round && (cmd.rnd == '0) |-> $past(cmd.load))
    else $error("first round without a load");

  // the output register is written only when its transaction is free
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !ct_out.valid || ct_out.ready)
    else $error("output register overwritten");

  // no load while a round runs
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(cmd.load && cmd.round))
    else $error("load and round in the same cycle");

endmodule

[bench/led64_block_encrypt_top_tb.sv]
// self-checking testbench for the led64 block encryption top level
`timescale 1ns / 1ps

module led64_block_encrypt_top_tb;
  import led64_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 6;
  localparam int ROUNDS       = LED_NUM_ROUNDS;
  localparam int LATENCY      = ROUNDS + 2;
  localparam int HOLD_CYCLES  = 200;
  localparam int PHASE_BLOCKS = 255;
  localparam int NUM_PHASES   = 6;
  localparam longint TIMEOUT_NS = 64'd1_000_000 * CLK_PERIOD;

  // key-size nibble mixed with the row number, column 0 of each row
  localparam logic [63:0] ROW_CONST = 64'h4000500020003000;
  // present s-box, entry i in nibble i
  localparam logic [15:0][3:0] SBOX = 64'h21748FE3DA09B65C;
  // mds rows, element k of a row in bits 15-4k..12-4k
  localparam logic [3:0][15:0] MDS_ROWS = {16'h22FB, 16'hBEA9, 16'h8656, 16'h4122};

  logic clk;
  logic rst;
  logic key_wr_en;
  logic [LED_KEY_W-1:0] key_wr_data;

  led64_pt_if pt_bus ();
  led64_ct_if ct_bus ();

  logic [63:0] cipher_key_shadow = '0;
  logic [63:0] pending_ciphertext[$];
  int mismatch_count = 0;
  bit pt_gap_on = 1'b1;
  bit ct_stall_on = 1'b1;
  int ct_hold_cycles = 0;

  led64_block_encrypt_top dut (
    .clk         (clk),
    .rst         (rst),
    .key_wr_en   (key_wr_en),
    .key_wr_data (key_wr_data),
    .pt_in       (pt_bus),
    .ct_out      (ct_bus)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // multiply in gf(16) modulo x^4+x+1
  function automatic logic [3:0] gf16_mul(input logic [3:0] a, input logic [3:0] b);
    logic [3:0] x;
    logic [3:0] acc;
    x = a;
    acc = '0;
    for (int i = 0; i < 4; i++) begin
      if (b[i]) acc ^= x;
      x = {x[2:0], 1'b0} ^ (x[3] ? 4'h3 : 4'h0);
    end
    return acc;
  endfunction

  // one round: add constants, s-box, row rotation, column mixing
  function automatic logic [63:0] led_round(input logic [63:0] s, input logic [5:0] rc);
    logic [63:0] shifted;
    logic [63:0] mixed;
    logic [3:0]  acc;
    s ^= ROW_CONST | ({61'd0, rc[5:3]} << 56) | ({61'd0, rc[2:0]} << 40)
       | ({61'd0, rc[5:3]} << 24) | ({61'd0, rc[2:0]} << 8);
    for (int k = 0; k < 16; k++)
      s[63-4*k -: 4] = SBOX[s[63-4*k -: 4]];
    for (int row = 0; row < 4; row++)
      for (int col = 0; col < 4; col++)
        shifted[63-4*(row*4+col) -: 4] = s[63-4*(row*4+((col+row)%4)) -: 4];
    for (int col = 0; col < 4; col++)
      for (int row = 0; row < 4; row++) begin
        acc = '0;
        for (int k = 0; k < 4; k++)
          acc ^= gf16_mul(MDS_ROWS[row][15-4*k -: 4], shifted[63-4*(k*4+col) -: 4]);
        mixed[63-4*(row*4+col) -: 4] = acc;
      end
    return mixed;
  endfunction

  // full encryption; round constants come from the 6-bit lfsr
  function automatic logic [63:0] led_encrypt_block(input logic [63:0] pt,
                                                    input logic [63:0] key);
    logic [63:0] s;
    logic [5:0]  rc;
    int          total;
    total = (ROUNDS > 48) ? 48 : ROUNDS;
    s = pt ^ key;
    rc = 6'h01;
    for (int r = 0; r < total; r++) begin
      s = led_round(s, rc);
      // key after every fourth round and after a partial last group
      if ((r % 4) == 3 || r + 1 == total) s ^= key;
      rc = {rc[4:0], rc[5] ^ rc[4] ^ 1'b1};
    end
    return s;
  endfunction

  // random block, sometimes sparse or dense
  function automatic logic [63:0] rand_block();
    case ($urandom_range(0, 9))
      0:       return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
      1:       return {$urandom, $urandom} | {$urandom, $urandom} | {$urandom, $urandom};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // offer one plaintext and wait for its transaction
  task automatic send_block(input logic [63:0] data);
    int gap;
    gap = pt_gap_on ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      pt_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pt_bus.valid <= 1'b1;
    pt_bus.plaintext <= data;
    do @(posedge clk); while (!(pt_bus.valid && pt_bus.ready));
  endtask

  // stop offering and let every ciphertext come back
  task automatic drain();
    pt_bus.valid <= 1'b0;
    // wait for a clock so the checker has queued the last accepted block
    @(posedge clk);
    while (pending_ciphertext.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  // key write, only with the core idle
  task automatic write_key(input logic [63:0] key);
    drain();
    key_wr_en <= 1'b1;
    key_wr_data <= key;
    cipher_key_shadow = key;
    @(posedge clk);
    key_wr_en <= 1'b0;
  endtask

  // key left at its reset value
  task automatic test_reset_key();
    send_block(64'h0);
    send_block(64'hFFFF_FFFF_FFFF_FFFF);
    send_block(64'h5555_5555_5555_5555);
    send_block(64'hAAAA_AAAA_AAAA_AAAA);
    send_block(64'h0123_4567_89AB_CDEF);
    send_block(64'h8000_0000_0000_0001);
  endtask

  // extreme and patterned keys
  task automatic test_key_extremes();
    write_key(64'hFFFF_FFFF_FFFF_FFFF);
    send_block(64'h0);
    send_block(64'hFFFF_FFFF_FFFF_FFFF);
    send_block(64'h0123_4567_89AB_CDEF);
    write_key(64'h0);
    send_block(64'hFEDC_BA98_7654_3210);
    write_key(64'h0123_4567_89AB_CDEF);
    send_block(64'h0123_4567_89AB_CDEF);
    send_block(64'hFEDC_BA98_7654_3210);
    send_block(64'h0);
  endtask

  // receiver holds off while the sender floods the input
  task automatic test_backpressure();
    bit saved_gap;
    write_key({$urandom, $urandom});
    saved_gap = pt_gap_on;
    pt_gap_on = 1'b0;
    ct_hold_cycles = HOLD_CYCLES;
    repeat (12) send_block(rand_block());
    pt_gap_on = saved_gap;
  endtask

  // random blocks under a new key per phase, idling switched on and off in stretches
  task automatic test_random_blocks();
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_key((p == 3) ? 64'h0 : {$urandom, $urandom});
      for (int i = 0; i < PHASE_BLOCKS; i++) begin
        if ($urandom_range(0, 31) == 0) pt_gap_on = !pt_gap_on;
        send_block(rand_block());
      end
    end
  endtask

  // stimulus and end of run
  initial begin
    rst <= 1'b1;
    key_wr_en <= 1'b0;
    key_wr_data <= '0;
    pt_bus.valid <= 1'b0;
    pt_bus.plaintext <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_key();
    test_key_extremes();
    test_backpressure();
    test_random_blocks();
    drain();
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // ciphertext receiver with random stalls and one long hold-off
  initial begin : ct_receiver
    int stall;
    ct_bus.ready <= 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      if ($urandom_range(0, 31) == 0) ct_stall_on = !ct_stall_on;
      if (ct_hold_cycles > 0) begin
        stall = ct_hold_cycles;
        ct_hold_cycles = 0;
      end else begin
        stall = ct_stall_on ? $urandom_range(0, 9) : 0;
      end
      if (stall > 0) begin
        ct_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      ct_bus.ready <= 1'b1;
      do @(posedge clk); while (!(ct_bus.valid && ct_bus.ready));
    end
  end

  // predict on each plaintext transaction, compare on each ciphertext transaction
  initial begin : ct_checker
    logic [63:0] want;
    forever begin
      @(posedge clk);
      if (rst === 1'b0) begin
        if (pt_bus.valid && pt_bus.ready)
          pending_ciphertext.push_back(led_encrypt_block(pt_bus.plaintext, cipher_key_shadow));
        if (ct_bus.valid && ct_bus.ready) begin
          if (pending_ciphertext.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected ciphertext, expected none, actual %h",
                     $time, ct_bus.ciphertext);
          end else begin
            want = pending_ciphertext.pop_front();
            if (ct_bus.ciphertext !== want) begin
              mismatch_count++;
              $display("%0t: ciphertext mismatch, expected %h, actual %h",
                       $time, want, ct_bus.ciphertext);
            end
          end
        end
      end
    end
  end

  // run limit
  initial begin
    #(TIMEOUT_NS);
    $display("FAILURE");
    $finish;
  end

endmodule

[filelist.f]
hdl/led64_pkg.sv
hdl/led64_if.sv
hdl/led64_dp.sv
hdl/led64_ctrl.sv
hdl/led64_block_encrypt_top.sv
bench/led64_block_encrypt_top_tb.sv
